// ----- src/ssnd_pkg.sv -----
package ssnd_pkg;

  localparam int DIGIT_CELLS = 9;
  localparam int IMAGE_BYTES = 16;
  localparam int POS_W = 4;

  localparam logic [31:0] SAT_LIMIT  = 32'd999999999;
  localparam logic [31:0] ICON_LIMIT = 32'd99999999;
  localparam logic [7:0] HEADER_CMD = 8'hE8;
  localparam logic [7:0] FGE_MASK   = 8'h70;
  localparam logic [7:0] ABCD_MASK  = 8'h0F;
  localparam logic [7:0] D_SEG      = 8'h08;
  localparam logic [7:0] DASH_GLYPH = 8'h02;
  localparam logic [7:0] TOP_BIT    = 8'h80;
  localparam logic [POS_W-1:0] MINUS_BYTE = 4'd13;

  typedef enum logic [1:0] {
    MODE_PRINT = 2'd0,
    MODE_ICON  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CMP,
    ST_HDR0,
    ST_HDR1,
    ST_BODY
  } state_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    begin
      case (d)
        4'd0: g = 8'h7D;
        4'd1: g = 8'h60;
        4'd2: g = 8'h3E;
        4'd3: g = 8'h7A;
        4'd4: g = 8'h63;
        4'd5: g = 8'h5B;
        4'd6: g = 8'h5F;
        4'd7: g = 8'h70;
        4'd8: g = 8'h7F;
        4'd9: g = 8'h7B;
        default: g = 8'h00;
      endcase
      return g;
    end
  endfunction

endpackage

// ----- src/ssnd_div10.sv -----
// One digit per cycle: quotient and remainder of a 30-bit magnitude by ten
module ssnd_div10 (
  input  logic [29:0] num,
  output logic [29:0] quot,
  output logic [3:0]  rem
);
  logic [63:0] prod;
  logic [29:0] q0;
  logic [33:0] back;
  logic [33:0] diff;

  // multiply by the reciprocal 2^35 / 10, exact over the whole input range
  assign prod = {34'd0, num} * 64'h0000_0000_CCCC_CCCD;
  assign q0   = {1'b0, prod[63:35]};
  assign back = {4'd0, q0} * 34'd10;
  assign diff = {4'd0, num} - back;

  assign quot = q0;
  assign rem  = diff[3:0];
endmodule

// ----- src/seven_segment_number_display.sv -----
// Seven-segment number display driver.
// Input channel s_axis: one item is a command (print number, icon write,
// clear image, flush). Output channel m_axis: bytes for the display
// controller, produced only by a flush that finds the image changed or
// no header sent yet: header 0xE8, 0x00, then the 16 image bytes,
// tlast on the final one. Print fills one digit per cycle from a shared
// divide-by-ten unit walking the nine cells right to left. Icon write
// and clear update the image directly from the idle state. Flush
// compares the image byte by byte against the sent copy, then sends
// its 18 output bytes, advancing only while m_axis_tready is high.
// s_axis_tready is low while any item is in work.
// Reset clears both images, the header flag and the sequencer.
// When the receiver stalls, the current output byte holds on m_axis_tdata
// and the sequencer waits; no byte is lost or repeated.
module seven_segment_number_display (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mode[1:0], value[33:2], precision[36:34], byte_pos[40:37],
  // seg_mask[48:41], seg_on[49], zero fill up to 56 bits
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import ssnd_pkg::*;

  logic [7:0] disp [IMAGE_BYTES];
  logic [7:0] sent [IMAGE_BYTES];
  logic       header_sent;
  state_t     state, state_next;
  logic [3:0] cnt;
  logic       diff_seen;
  logic [29:0] mag;
  logic [3:0]  show;
  logic        neg_glyph;
  logic [2:0]  prec;

  logic [1:0]  in_mode;
  logic [31:0] in_value;
  logic [2:0]  in_prec;
  logic [3:0]  in_pos;
  logic [7:0]  in_mask;
  logic        in_on;
  logic        in_acc;
  logic        out_acc;

  assign in_mode  = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[33:2];
  assign in_prec  = s_axis_tdata[36:34];
  assign in_pos   = s_axis_tdata[40:37];
  assign in_mask  = s_axis_tdata[48:41];
  assign in_on    = s_axis_tdata[49];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;

  // bits of one image byte kept when a print starts
  function automatic logic [7:0] print_keep(input int b);
    logic [7:0] keep;
    keep = 8'hFF;
    if (b >= 15 - DIGIT_CELLS && b <= 14) keep = keep & ~FGE_MASK;
    if (b >= 14 - DIGIT_CELLS && b <= 13) keep = keep & ~ABCD_MASK;
    if (b >= 6 && b <= 10) keep = keep & ~TOP_BIT;
    if (b == int'(MINUS_BYTE)) keep = keep & ~TOP_BIT;
    return keep;
  endfunction

  // saturated magnitude, sign handling and digit count of the input value
  logic        v_neg;
  logic [31:0] v_abs;
  logic [29:0] sat_mag;
  logic        icon;
  logic [3:0]  nd;
  logic [3:0]  show_in;
  always_comb begin
    v_neg = in_value[31];
    v_abs = v_neg ? (32'd0 - in_value) : in_value;
    sat_mag = (v_abs > SAT_LIMIT) ? SAT_LIMIT[29:0] : v_abs[29:0];
    icon = v_neg && (v_abs > ICON_LIMIT);
    nd = 4'd1;
    if (sat_mag >= 30'd10)        nd = 4'd2;
    if (sat_mag >= 30'd100)       nd = 4'd3;
    if (sat_mag >= 30'd1000)      nd = 4'd4;
    if (sat_mag >= 30'd10000)     nd = 4'd5;
    if (sat_mag >= 30'd100000)    nd = 4'd6;
    if (sat_mag >= 30'd1000000)   nd = 4'd7;
    if (sat_mag >= 30'd10000000)  nd = 4'd8;
    if (sat_mag >= 30'd100000000) nd = 4'd9;
    show_in = ({1'b0, in_prec} + 4'd1 > nd) ? ({1'b0, in_prec} + 4'd1) : nd;
    if (show_in > 4'(DIGIT_CELLS)) show_in = 4'(DIGIT_CELLS);
  end

  // shared divide-by-ten unit
  logic [29:0] quot;
  logic [3:0]  rem;
  ssnd_div10 u_div (.num(mag), .quot(quot), .rem(rem));

  // cell being written: k = cnt counts from the right
  logic [3:0]       cell_idx;
  logic [POS_W-1:0] hi_idx, lo_idx;
  logic [7:0]       glyph;
  logic             put;
  always_comb begin
    cell_idx = 4'(DIGIT_CELLS - 1) - cnt;
    hi_idx   = POS_W'(4'd14 - cell_idx);
    lo_idx   = POS_W'(4'd13 - cell_idx);
    put      = 1'b1;
    if (cnt < show)                    glyph = digit_glyph(rem);
    else if (cnt == show && neg_glyph) glyph = DASH_GLYPH;
    else begin
      glyph = 8'h00;
      put   = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_PRINT)      state_next = ST_CONV;
          else if (in_mode == MODE_FLUSH) state_next = ST_CMP;
        end
      end
      ST_CONV: if (cnt == 4'(DIGIT_CELLS - 1)) state_next = ST_IDLE;
      ST_CMP: begin
        if (cnt == 4'(IMAGE_BYTES - 1))
          state_next = (header_sent && !diff_seen &&
                        disp[cnt] == sent[cnt]) ? ST_IDLE : ST_HDR0;
      end
      ST_HDR0: if (out_acc) state_next = ST_HDR1;
      ST_HDR1: if (out_acc) state_next = ST_BODY;
      ST_BODY: if (out_acc && cnt == 4'(IMAGE_BYTES - 1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tdata  = 8'h00;
    m_axis_tlast  = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_HDR0: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = HEADER_CMD;
      end
      ST_HDR1: m_axis_tvalid = 1'b1;
      ST_BODY: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = sent[cnt];
        m_axis_tlast  = (cnt == 4'(IMAGE_BYTES - 1));
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      diff_seen   <= 1'b0;
      header_sent <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt       <= '0;
          diff_seen <= 1'b0;
        end
        ST_CONV: cnt <= cnt + 4'd1;
        ST_CMP: begin
          if (disp[cnt] != sent[cnt]) diff_seen <= 1'b1;
          cnt <= cnt + 4'd1;
          if (state_next == ST_HDR0) header_sent <= 1'b1;
        end
        ST_BODY: if (out_acc) cnt <= cnt + 4'd1;
        default: ;
      endcase
    end
  end

  // image storage and conversion payload
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IMAGE_BYTES; i++) begin
        disp[i] <= 8'h00;
        sent[i] <= 8'h00;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              MODE_PRINT: begin
                mag       <= sat_mag;
                show      <= show_in;
                neg_glyph <= v_neg && !icon && (sat_mag != 30'd0);
                prec      <= in_prec;
                // drop dots and cell glyphs, set or drop the minus icon
                for (int b = 0; b < IMAGE_BYTES; b++) begin
                  disp[b] <= (disp[b] & print_keep(b)) |
                    ((b == int'(MINUS_BYTE) && icon) ? TOP_BIT : 8'h00);
                end
              end
              MODE_ICON: begin
                if (in_on) disp[in_pos] <= disp[in_pos] | in_mask;
                else       disp[in_pos] <= disp[in_pos] & ~in_mask;
              end
              MODE_CLEAR: begin
                for (int i = 0; i < IMAGE_BYTES; i++) disp[i] <= 8'h00;
              end
              default: ;
            endcase
          end
        end
        ST_CONV: begin
          mag <= quot;
          if (put) begin
            disp[hi_idx] <= disp[hi_idx] | ((glyph << 4) & FGE_MASK);
            disp[lo_idx] <= disp[lo_idx] | (((glyph >> 4) & ABCD_MASK) | (glyph & D_SEG));
          end
          if (cnt == 4'(DIGIT_CELLS - 1) && prec >= 3'd1 && prec <= 3'd5)
            disp[POS_W'(4'd5 + {1'b0, prec})][7] <= 1'b1;
        end
        ST_CMP: begin
          if (state_next == ST_HDR0)
            for (int i = 0; i < IMAGE_BYTES; i++) sent[i] <= disp[i];
        end
        default: ;
      endcase
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken during flush");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (state == ST_BODY))
    else $error("tlast outside image bytes");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_HDR0) |-> header_sent)
    else $error("header flag not set");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled byte changed");
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ssnd_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  seven_segment_number_display i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } lcd_byte_t;

  // predicted state of the block
  logic [7:0] img [IMAGE_BYTES];
  logic [7:0] sent_img [IMAGE_BYTES];
  logic       hdr_done;
  lcd_byte_t  lcd_queue [$];

  int  error_count;
  int  cycle_count;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  rx_hold_cycles;
  int  long_hold_seq;
  int  long_hold_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // end the run at a generous cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("seven_segment_number_display verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [7:0] glyph_of(input int d);
    logic [7:0] g;
    case (d)
      0: g = 8'h7D; 1: g = 8'h60; 2: g = 8'h3E; 3: g = 8'h7A; 4: g = 8'h63;
      5: g = 8'h5B; 6: g = 8'h5F; 7: g = 8'h70; 8: g = 8'h7F; default: g = 8'h7B;
    endcase
    return g;
  endfunction

  task automatic draw_cell(input int c, input logic [7:0] g);
    img[(14 - c) & 15] |= (g << 4) & FGE_MASK;
    img[(13 - c) & 15] |= ((g >> 4) & ABCD_MASK) | (g & D_SEG);
  endtask

  // render a number into the predicted image
  task automatic render_number(input logic signed [31:0] value, input int prec);
    longint v;
    longint mag;
    longint t;
    bit     dash;
    int     nd;
    int     shown;
    v = value;
    dash = 0;
    if (v > 999999999) v = 999999999;
    if (v < -999999999) v = -999999999;
    for (int k = 0; k < 5; k++) img[6 + k] &= ~TOP_BIT;
    for (int c = 0; c < DIGIT_CELLS; c++) begin
      img[(14 - c) & 15] &= ~FGE_MASK;
      img[(13 - c) & 15] &= ~ABCD_MASK;
    end
    if (v < -99999999) begin
      img[MINUS_BYTE] |= TOP_BIT;
      mag = -v;
    end else begin
      img[MINUS_BYTE] &= ~TOP_BIT;
      dash = (v < 0);
      mag = dash ? -v : v;
    end
    nd = 1;
    for (t = mag / 10; t != 0; t = t / 10) nd++;
    shown = (prec + 1 > nd) ? prec + 1 : nd;
    if (shown > DIGIT_CELLS) shown = DIGIT_CELLS;
    for (int k = 0; k < DIGIT_CELLS; k++) begin
      if (k < shown) begin
        draw_cell(DIGIT_CELLS - 1 - k, glyph_of(int'(mag % 10)));
        mag = mag / 10;
      end else if (k == shown && dash) begin
        draw_cell(DIGIT_CELLS - 1 - k, DASH_GLYPH);
      end
    end
    if (prec >= 1 && prec <= 5) img[5 + prec] |= TOP_BIT;
  endtask

  // update the predicted image and queue expected bytes
  task automatic predict_command(input logic [55:0] d);
    mode_t mode;
    bit    same;
    mode = mode_t'(d[1:0]);
    case (mode)
      MODE_PRINT: render_number(d[33:2], int'(d[36:34]));
      MODE_ICON: begin
        if (d[49]) img[d[40:37]] |= d[48:41];
        else img[d[40:37]] &= ~d[48:41];
      end
      MODE_CLEAR: for (int i = 0; i < IMAGE_BYTES; i++) img[i] = 8'h00;
      default: begin
        same = 1;
        for (int i = 0; i < IMAGE_BYTES; i++) if (img[i] != sent_img[i]) same = 0;
        if (!(hdr_done && same)) begin
          hdr_done = 1;
          lcd_queue.push_back('{HEADER_CMD, 1'b0});
          lcd_queue.push_back('{8'h00, 1'b0});
          for (int i = 0; i < IMAGE_BYTES; i++) begin
            sent_img[i] = img[i];
            lcd_queue.push_back('{img[i], i == IMAGE_BYTES - 1});
          end
        end
      end
    endcase
  endtask

  // send one item, with random idle bursts before it; valid stays high after
  // the accepting edge until the next item or an explicit drop
  task automatic send_command(input mode_t mode, input logic signed [31:0] value,
                              input int prec, input int pos,
                              input int mask, input int on);
    logic [55:0] d;
    d = {6'd0, on[0], mask[7:0], pos[3:0], prec[2:0], value, mode};
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_command(d);
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (lcd_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_seq != long_hold_seen) begin
      long_hold_seen <= long_hold_seq;
      rx_hold_cycles <= 300;
      m_axis_tready  <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      m_axis_tready  <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_hold_cycles <= $urandom_range(1, 14);
      m_axis_tready  <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // check each output byte against the oldest expectation
  always @(posedge clk) begin
    lcd_byte_t exp_b;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (lcd_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
      end else begin
        exp_b = lcd_queue.pop_front();
        if (m_axis_tdata !== exp_b.data)
          report_mismatch($sformatf("byte %02h, want %02h", m_axis_tdata, exp_b.data));
        if (m_axis_tlast !== exp_b.last)
          report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, exp_b.last));
      end
    end
  end

  task automatic flush_cmd;
    send_command(MODE_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed_print;
    send_command(MODE_FLUSH, 0, 0, 0, 0, 0);          // first flush, blank image
    flush_cmd();                                       // unchanged, nothing sent
    send_command(MODE_PRINT, 32'sd0, 0, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, 32'sd2147483647, 3, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, -32'sd2147483648, 0, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, -32'sd99999999, 2, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, -32'sd100000000, 5, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, -32'sd7, 7, 0, 0, 0);    // padding, no dot
    flush_cmd();
    send_command(MODE_PRINT, 32'sd123456789, 6, 0, 0, 0);
    flush_cmd();
    send_command(MODE_PRINT, -32'sd1234, 1, 0, 0, 0);
    flush_cmd();
  endtask

  task automatic test_directed_icons;
    send_command(MODE_ICON, 0, 0, 0, 'hFF, 1);
    send_command(MODE_ICON, 0, 0, 15, 'hA5, 1);
    flush_cmd();
    send_command(MODE_ICON, 0, 0, 15, 'h05, 0);
    send_command(MODE_ICON, 0, 0, 13, 'h80, 1);
    flush_cmd();
    send_command(MODE_CLEAR, 0, 0, 0, 0, 0);
    flush_cmd();
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 200000000)) - 100000000;
      3: return $urandom_range(0, 999999999);
      default: return -$signed($urandom_range(0, 1100000000));
    endcase
  endfunction

  task automatic test_random_commands(input int n);
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 9);
      if (m < 4) send_command(MODE_PRINT, pick_value(), $urandom, $urandom, $urandom, $urandom);
      else if (m < 6) send_command(MODE_ICON, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (m == 6) send_command(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                    $urandom);
      else flush_cmd();
    end
  endtask

  // hold the receiver off so that later commands wait behind a stalled flush
  task automatic test_receiver_backlog;
    s_axis_tvalid <= 1'b0;
    long_hold_seq++;
    @(posedge clk);
    send_command(MODE_PRINT, pick_value(), 2, 0, 0, 0);
    flush_cmd();
    send_command(MODE_ICON, 0, 0, 3, 'h11, 1);
    flush_cmd();
    wait_drained();
  endtask

  initial begin
    tx_idle_en    = 1;
    rx_idle_en    = 1;
    hdr_done      = 0;
    for (int i = 0; i < IMAGE_BYTES; i++) begin
      img[i] = 8'h00;
      sent_img[i] = 8'h00;
    end
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_print();
    test_directed_icons();
    wait_drained();
    test_random_commands(40);
    test_receiver_backlog();
    test_random_commands(20);
    wait_drained();
    tx_idle_en = 0;
    rx_idle_en = 0;
    test_random_commands(20);
    wait_drained();

    if (error_count == 0) begin
      $display("seven_segment_number_display verification clean");
    end else begin
      $display("seven_segment_number_display verification failed");
    end
    $finish;
  end

endmodule
